### rtl/fabrik_chain_solver_macros.svh
// Assertion macros for the FABRIK chain solver checker.
`ifndef FABRIK_CHAIN_SOLVER_MACROS_SVH
`define FABRIK_CHAIN_SOLVER_MACROS_SVH

// Same-cycle implication.
`define FCS_AST_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fcs port check failed");

// Next-cycle implication.
`define FCS_AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fcs port check failed");

`endif

### rtl/fcs_pkg.sv
// Shared constants, types and sequencer states of the FABRIK chain solver.
package fcs_pkg;

    localparam int MAX_JOINTS = 16;
    localparam int JNT_AW     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_JOINTS + 1);
    localparam int CRD_W      = 32;
    localparam int IDX_W      = 4;
    localparam int LIM_W      = 8;
    localparam int TOL_W      = 31;
    localparam int CFG_AW     = 8;
    localparam int CFG_DW     = 32;

    localparam logic [LIM_W-1:0]  LIMIT_RST = 8'd10;
    localparam logic [TOL_W-1:0]  TOL_RST   = 31'd66;
    localparam logic [30:0]       COORD_MAX = 31'h7FFF_FFFF;

    localparam logic [CFG_AW-1:0] CFG_ITER_LIMIT = 8'd0;
    localparam logic [CFG_AW-1:0] CFG_REACH_TOL  = 8'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef logic signed [CRD_W-1:0] t_coord;
    typedef logic [2:0][CRD_W-1:0]   t_pt;      // [0] x, [1] y, [2] z
    typedef logic [JNT_AW-1:0]       t_jaddr;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [5:0] {
        S_IDLE,
        S_LD_RD, S_LD_DIF, S_LD_ACC,
        S_SV_ORG, S_SV_DIF, S_SV_CHK,
        S_UR_RD, S_UR_GO, S_UR_NXT,
        S_IT_TOP, S_END_RD, S_END_DIF, S_END_CHK,
        S_BW_RA, S_BW_RB, S_BW_GO, S_BW_NXT,
        S_FW_RA, S_FW_RB, S_FW_GO, S_FW_NXT,
        S_LEN_SQ, S_LEN_ACC, S_LEN_GO, S_LEN_RT,
        S_PL_MUL, S_PL_DIV, S_PL_WAIT, S_PL_FIN,
        S_EM_RD, S_EM_LD, S_EM_OUT
    } t_state;

endpackage

### rtl/fcs_if.sv
// Request, result and configuration channel interfaces.
interface fcs_req_if import fcs_pkg::*; ;
    logic   valid;
    logic   ready;
    logic   operation;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    logic   chain_end;
    modport source (output valid, operation, point_x, point_y, point_z, chain_end,
                    input ready);
    modport sink   (input valid, operation, point_x, point_y, point_z, chain_end,
                    output ready);
endinterface

interface fcs_res_if import fcs_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] joint_index;
    t_coord           joint_x;
    t_coord           joint_y;
    t_coord           joint_z;
    logic             reached;
    logic             final_joint;
    modport source (output valid, joint_index, joint_x, joint_y, joint_z, reached,
                    final_joint, input ready);
    modport sink   (input valid, joint_index, joint_x, joint_y, joint_z, reached,
                    final_joint, output ready);
endinterface

interface fcs_cfg_if import fcs_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fcs_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module fcs_sqrt import fcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
        rem_sh = {r_rem, r_x[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### rtl/fcs_div.sv
// Restoring divider, one quotient bit per cycle.
module fcs_div import fcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_dvd,
    input  logic [30:0] i_dvs,
    output logic        o_done,
    output logic [61:0] o_quot
);
    logic [61:0] r_q;
    logic [30:0] r_rem;
    logic [30:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] rem_sh;
    logic        ge;

    always_comb begin
        rem_sh = {r_rem, r_q[61]};
        ge     = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd61) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_q   <= {r_q[60:0], ge};
            r_rem <= ge ? 31'(rem_sh - {1'b0, r_dvs}) : rem_sh[30:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### rtl/fabrik_chain_solver.sv
// FABRIK chain solver top level: sequencer, joint store and shared arithmetic.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  i_req    | in  | valid/ready   | operation, point_x/y/z, chain_end
//  o_res    | out | valid/ready   | joint_index, joint_x/y/z, reached, final_joint
//  i_cfg    | in  | valid/ready   | index, data (0 iteration_limit, 1 reach_tolerance)
//
// One request at a time; i_req.ready is high only while the sequencer idles.
// A length takes three squares and a 32-step root; placing a joint in a pass takes
// a length plus three 62-step divisions. A reachable target is solved by backward
// and forward pass pairs over the joints; each joint is then emitted in turn.
// Synchronous active-low reset clears control state; the joint store needs no clearing.
// A stalled result holds in the output register until taken.
module fabrik_chain_solver import fcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcs_req_if.sink   i_req,
    fcs_res_if.source o_res,
    fcs_cfg_if.sink   i_cfg
);
    t_state            r_st, n_st, r_ret, r_pret;
    logic [LIM_W-1:0]  r_limit, r_it;
    logic [TOL_W-1:0]  r_tol;
    logic [31:0]       r_reach;
    t_cnt              r_cnt;
    logic              r_closed;
    t_jaddr            r_idx;
    logic [1:0]        r_k;
    t_pt               r_t, r_org, r_a, r_b, r_d, r_p;
    logic [30:0]       r_len, r_plen, r_q;
    logic [61:0]       r_prod;
    logic [63:0]       r_sum;
    logic              r_hit, r_fin;
    t_pt               r_o_pt;
    logic              r_o_last;
    t_jaddr            r_o_idx;

    t_pt               mem_j [MAX_JOINTS];
    logic [31:0]       mem_s [MAX_JOINTS];
    t_pt               r_rd;
    logic [31:0]       r_srd;

    t_jaddr            rd_addr, sd_addr, wr_addr;
    logic              wr_en, seg_we;
    t_pt               wr_data;
    logic              sq_start, sq_done, dv_start, dv_done;
    logic [31:0]       sq_root;
    logic [61:0]       dv_quot;
    logic [30:0]       mul_a, mul_b;
    logic [61:0]       mul_p;
    t_coord            pnew;
    logic              in_acc;
    t_cnt              c0;
    logic              room;
    t_jaddr            last;
    t_pt               in_pt;
    logic [32:0]       reach_sum;

    function automatic t_pt diff3(input t_pt a, input t_pt b);
        logic signed [32:0] s;
        t_pt r;
        for (int c = 0; c < 3; c++) begin
            s = $signed({a[c][31], a[c]}) - $signed({b[c][31], b[c]});
            if (s > $signed({2'b00, COORD_MAX}))
                r[c] = {1'b0, COORD_MAX};
            else if (s < -$signed({2'b00, COORD_MAX}))
                r[c] = 32'(-$signed({2'b00, COORD_MAX}));
            else
                r[c] = s[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] mag31(input logic [31:0] v);
        logic [31:0] n;
        n = -v;
        return v[31] ? n[30:0] : v[30:0];
    endfunction

    function automatic t_coord place_c(input logic [31:0] b, input logic neg,
                                       input logic [30:0] q);
        logic signed [32:0] off;
        logic signed [32:0] s;
        off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        s   = $signed({b[31], b}) + off;
        if (s > $signed({2'b00, COORD_MAX}))
            return {1'b0, COORD_MAX};
        else if (s < -$signed({2'b00, COORD_MAX}) - 33'sd1)
            return {1'b1, 31'd0};
        else
            return s[31:0];
    endfunction

    fcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    fcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_dvd   (r_prod),
        .i_dvs   (r_len),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    always_comb begin
        in_acc    = i_req.valid && i_req.ready;
        c0        = r_closed ? '0 : r_cnt;
        room      = (c0 < CNT_W'(MAX_JOINTS));
        last      = JNT_AW'(r_cnt - 1'b1);
        in_pt     = {i_req.point_z, i_req.point_y, i_req.point_x};
        mul_a     = mag31(r_d[r_k]);
        mul_b     = (r_st == S_LEN_SQ) ? mul_a : r_plen;
        mul_p     = mul_a * mul_b;
        pnew      = place_c(r_b[r_k], r_d[r_k][31], r_q);
        reach_sum = {1'b0, r_reach} + {2'b00, r_len};
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req.operation == OP_LOAD)
                        n_st = (room && c0 != '0) ? S_LD_RD : S_IDLE;
                    else if (r_cnt >= t_cnt'(2))
                        n_st = S_SV_ORG;
                    else if (r_cnt != '0)
                        n_st = S_EM_RD;
                end
            end
            S_LD_RD:   n_st = S_LD_DIF;
            S_LD_DIF:  n_st = S_LEN_SQ;
            S_LD_ACC:  n_st = S_IDLE;
            S_SV_ORG:  n_st = S_SV_DIF;
            S_SV_DIF:  n_st = S_LEN_SQ;
            S_SV_CHK:  n_st = ({1'b0, r_len} > r_reach) ? S_UR_RD : S_IT_TOP;
            S_UR_RD:   n_st = S_UR_GO;
            S_UR_GO:   n_st = S_PL_MUL;
            S_UR_NXT:  n_st = (r_idx == last) ? S_EM_RD : S_UR_RD;
            S_IT_TOP:  n_st = S_END_RD;
            S_END_RD:  n_st = S_END_DIF;
            S_END_DIF: n_st = S_LEN_SQ;
            S_END_CHK: n_st = (r_len < r_tol || r_fin) ? S_EM_RD : S_BW_RA;
            S_BW_RA:   n_st = S_BW_RB;
            S_BW_RB:   n_st = S_BW_GO;
            S_BW_GO:   n_st = S_LEN_SQ;
            S_BW_NXT:  n_st = (r_idx == '0) ? S_FW_RA : S_BW_RA;
            S_FW_RA:   n_st = S_FW_RB;
            S_FW_RB:   n_st = S_FW_GO;
            S_FW_GO:   n_st = S_LEN_SQ;
            S_FW_NXT:  n_st = (r_idx == last) ? S_IT_TOP : S_FW_RA;
            S_LEN_SQ:  n_st = S_LEN_ACC;
            S_LEN_ACC: n_st = (r_k == 2'd2) ? S_LEN_GO : S_LEN_SQ;
            S_LEN_GO:  n_st = S_LEN_RT;
            S_LEN_RT:  n_st = sq_done ? r_ret : S_LEN_RT;
            S_PL_MUL:  n_st = S_PL_DIV;
            S_PL_DIV:  n_st = (r_len == '0) ? S_PL_FIN : S_PL_WAIT;
            S_PL_WAIT: n_st = dv_done ? S_PL_FIN : S_PL_WAIT;
            S_PL_FIN:  n_st = (r_k == 2'd2) ? r_pret : S_PL_MUL;
            S_EM_RD:   n_st = S_EM_LD;
            S_EM_LD:   n_st = S_EM_OUT;
            S_EM_OUT: begin
                if (o_res.ready)
                    n_st = r_o_last ? S_IDLE : S_EM_RD;
            end
            default:   n_st = S_IDLE;
        endcase
    end

    // control outputs: memory ports and unit starts
    always_comb begin
        rd_addr  = '0;
        sd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_t;
        seg_we   = 1'b0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (in_acc && i_req.operation == OP_LOAD && room) begin
                    wr_en   = 1'b1;
                    wr_addr = JNT_AW'(c0);
                    wr_data = in_pt;
                end
            end
            S_LD_RD:   rd_addr = r_idx - 1'b1;
            S_LD_ACC:  seg_we  = 1'b1;
            S_SV_ORG:  rd_addr = '0;
            S_UR_RD: begin
                rd_addr = r_idx - 1'b1;
                sd_addr = r_idx - 1'b1;
            end
            S_END_RD:  rd_addr = last;
            S_END_CHK: begin
                if (!(r_len < r_tol || r_fin)) begin
                    wr_en   = 1'b1;
                    wr_addr = last;
                    wr_data = r_t;
                end
            end
            S_BW_RA: begin
                rd_addr = r_idx;
                sd_addr = r_idx;
            end
            S_BW_RB:   rd_addr = r_idx + 1'b1;
            S_BW_NXT: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_org;
                end
            end
            S_FW_RA: begin
                rd_addr = r_idx;
                sd_addr = r_idx - 1'b1;
            end
            S_FW_RB:   rd_addr = r_idx - 1'b1;
            S_LEN_GO:  sq_start = 1'b1;
            S_PL_DIV:  dv_start = (r_len != '0);
            S_PL_FIN: begin
                if (r_k == 2'd2) begin
                    wr_en   = 1'b1;
                    wr_data = {pnew, r_p[1], r_p[0]};
                end
            end
            S_EM_RD:   rd_addr = r_idx;
            default: ;
        endcase
    end

    // joint and segment store, registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem_j[wr_addr] <= wr_data;
        if (seg_we)
            mem_s[r_idx - 1'b1] <= {1'b0, r_len};
        r_rd  <= mem_j[rd_addr];
        r_srd <= mem_s[sd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_limit  <= LIMIT_RST;
            r_tol    <= TOL_RST;
            r_reach  <= '0;
            r_cnt    <= '0;
            r_closed <= 1'b1;
            r_k      <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ITER_LIMIT: r_limit <= i_cfg.data[LIM_W-1:0];
                    CFG_REACH_TOL:  r_tol   <= i_cfg.data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (r_st == S_IDLE && in_acc && i_req.operation == OP_LOAD) begin
                r_closed <= i_req.chain_end;
                if (r_closed)
                    r_reach <= '0;
                r_cnt <= (room && c0 == '0) ? t_cnt'(1) : c0;
            end
            if (r_st == S_LD_ACC) begin
                r_reach <= reach_sum[32] ? 32'hFFFF_FFFF : reach_sum[31:0];
                r_cnt   <= t_cnt'(r_idx) + 1'b1;
            end
            if (r_st == S_LEN_ACC || r_st == S_PL_FIN)
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st) inside
            S_IDLE: begin
                r_t   <= in_pt;
                r_idx <= (i_req.operation == OP_LOAD) ? JNT_AW'(c0) : '0;
                r_hit <= 1'b0;
            end
            S_LD_DIF: begin
                r_d   <= diff3(r_t, r_rd);
                r_ret <= S_LD_ACC;
            end
            S_SV_DIF: begin
                r_org <= r_rd;
                r_d   <= diff3(r_t, r_rd);
                r_ret <= S_SV_CHK;
            end
            S_SV_CHK: begin
                r_idx <= t_jaddr'(1);
                r_it  <= '0;
            end
            S_UR_GO: begin
                r_b    <= r_rd;
                r_plen <= r_srd[30:0];
                r_pret <= S_UR_NXT;
            end
            S_UR_NXT: r_idx <= (r_idx == last) ? '0 : r_idx + 1'b1;
            S_IT_TOP: r_fin <= (r_it == r_limit);
            S_END_DIF: begin
                r_d   <= diff3(r_rd, r_t);
                r_ret <= S_END_CHK;
            end
            S_END_CHK: begin
                r_hit <= (r_len < r_tol);
                r_idx <= (r_len < r_tol || r_fin) ? '0 : last - 1'b1;
            end
            S_BW_RB, S_FW_RB: begin
                r_a    <= r_rd;
                r_plen <= r_srd[30:0];
            end
            S_BW_GO: begin
                r_b    <= r_rd;
                r_d    <= diff3(r_a, r_rd);
                r_ret  <= S_PL_MUL;
                r_pret <= S_BW_NXT;
            end
            S_BW_NXT: r_idx <= (r_idx == '0) ? t_jaddr'(1) : r_idx - 1'b1;
            S_FW_GO: begin
                r_b    <= r_rd;
                r_d    <= diff3(r_a, r_rd);
                r_ret  <= S_PL_MUL;
                r_pret <= S_FW_NXT;
            end
            S_FW_NXT: begin
                if (r_idx == last)
                    r_it <= r_it + 1'b1;
                else
                    r_idx <= r_idx + 1'b1;
            end
            S_LEN_SQ:  r_prod <= mul_p;
            S_LEN_ACC: r_sum  <= ((r_k == 2'd0) ? 64'd0 : r_sum) + 64'(r_prod);
            S_LEN_RT: begin
                if (sq_done)
                    r_len <= sq_root[31] ? COORD_MAX : sq_root[30:0];
            end
            S_PL_MUL:  r_prod <= mul_p;
            S_PL_DIV:  r_q    <= '0;
            S_PL_WAIT: begin
                if (dv_done)
                    r_q <= dv_quot[30:0];    // quotient never exceeds the segment length
            end
            S_PL_FIN:  r_p[r_k] <= pnew;
            S_EM_LD: begin
                r_o_pt   <= r_rd;
                r_o_idx  <= r_idx;
                r_o_last <= (r_idx == last);
            end
            S_EM_OUT: begin
                if (o_res.ready && !r_o_last)
                    r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    assign i_req.ready       = (r_st == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = (r_st == S_EM_OUT);
    assign o_res.joint_index = IDX_W'(r_o_idx);
    assign o_res.joint_x     = r_o_pt[0];
    assign o_res.joint_y     = r_o_pt[1];
    assign o_res.joint_z     = r_o_pt[2];
    assign o_res.reached     = r_hit;
    assign o_res.final_joint = r_o_last;
endmodule

### rtl/fcs_chk.sv
// Port-level checker for the FABRIK chain solver, bound to the top level.
`include "fabrik_chain_solver_macros.svh"

module fcs_chk import fcs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_final,
    input logic [IDX_W-1:0] i_out_index
);
    // a result on show means the sequencer is busy
    `FCS_AST_NOW(a_busy_emit, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    // stalled result holds
    `FCS_AST_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_index))
    // more joints to come: stay busy
    `FCS_AST_NEXT(a_more, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_final, !i_in_ready)
    // last joint taken: back to idle
    `FCS_AST_NEXT(a_done, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_final, !i_out_valid && i_in_ready)
endmodule

bind fabrik_chain_solver fcs_chk u_fcs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_final (o_res.final_joint),
    .i_out_index (o_res.joint_index)
);
